// ===== rtl/cdq_pkg.sv =====
// Shared types and codes for the circular deque.
package cdq_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned MODE_W = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CAP_W = 5;

   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_REAR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT = 2'd2;
   localparam logic [MODE_W-1:0] MODE_POP_REAR = 2'd3;

   localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic signed [VALUE_W-1:0] value;
   } cdq_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic signed [VALUE_W-1:0] front_value;
      logic signed [VALUE_W-1:0] rear_value;
      logic is_empty;
      logic is_full;
   } cdq_rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic read;
      logic load;
   } cdq_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic rsp_full;
   } cdq_stat_type;

endpackage

// ===== rtl/cdq_ctrl.sv =====
// Sequencer for the circular deque: accept, update, read, load result.
module cdq_ctrl
   import cdq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         rsp_ready,
   input  cdq_stat_type stat,
   output cdq_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_LOAD = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       load_ok;

   assign load_ok = !stat.rsp_full || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            // hold until the output register is free
            if (load_ok) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/cdq_dp.sv =====
// Datapath of the circular deque: indices, store, capacity and result register.
module cdq_dp
   import cdq_pkg::*;
#(
   parameter int unsigned DEPTH = 16
)
(
   input  logic             clock,
   input  logic             reset,
   input  cdq_req_type      req_data,
   output cdq_rsp_type      rsp_data,
   input  logic             rsp_ready,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata,
   input  cdq_cmd_type      cmd,
   output cdq_stat_type     stat
);

   localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = IW + 1;
   localparam int unsigned KW = (CW > CAP_W) ? CW : CAP_W;
   localparam logic [KW-1:0] DEPTH_K = KW'(DEPTH);
   localparam logic [CW-1:0] CAP_RST = CW'((16 > DEPTH) ? DEPTH : 16);

   logic [VALUE_W-1:0] store [DEPTH];

   logic [MODE_W-1:0]   mode_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [IW-1:0]       head_ff, head_in;
   logic [IW-1:0]       tail_ff, tail_in;
   logic                empty_ff, empty_in;
   logic [CW-1:0]       cap_ff, cap_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [VALUE_W-1:0]  rd_head_ff, rd_tail_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   cdq_rsp_type         rsp_ff, rsp_in;

   logic [KW-1:0] wd_ext;
   logic [CW-1:0] cap_wr;
   logic [IW-1:0] head_inc, head_dec, tail_inc, tail_dec;
   logic          full_now;
   logic          mem_we;
   logic [IW-1:0] mem_addr;

   // wrap steps against the capacity in use
   assign head_inc = (CW'(head_ff) + 1'b1 >= cap_ff) ? '0 : head_ff + 1'b1;
   assign tail_inc = (CW'(tail_ff) + 1'b1 >= cap_ff) ? '0 : tail_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? IW'(cap_ff - 1'b1) : head_ff - 1'b1;
   assign tail_dec = (tail_ff == '0) ? IW'(cap_ff - 1'b1) : tail_ff - 1'b1;
   assign full_now = !empty_ff && (tail_inc == head_ff);

   // clamp a written capacity to 1..DEPTH
   assign wd_ext = KW'(csr_wdata);
   always_comb begin
      if (wd_ext == '0) begin
         cap_wr = CW'(1);
      end else if (wd_ext > DEPTH_K) begin
         cap_wr = CW'(DEPTH_K);
      end else begin
         cap_wr = CW'(wd_ext);
      end
   end

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      empty_in = empty_ff;
      cap_in = cap_ff;
      status_in = status_ff;
      mem_we = 1'b0;
      mem_addr = '0;
      if (csr_we) begin
         cap_in = cap_wr;
         head_in = '0;
         tail_in = '0;
         empty_in = 1'b1;
      end else if (cmd.exec) begin
         status_in = ST_DONE;
         unique case (mode_ff)
            MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
               if (empty_ff) begin
                  head_in = '0;
                  tail_in = '0;
                  empty_in = 1'b0;
                  mem_we = 1'b1;
               end else if (full_now) begin
                  status_in = ST_FULL;
               end else if (mode_ff == MODE_PUSH_FRONT) begin
                  head_in = head_dec;
                  mem_we = 1'b1;
                  mem_addr = head_dec;
               end else begin
                  tail_in = tail_inc;
                  mem_we = 1'b1;
                  mem_addr = tail_inc;
               end
            end
            MODE_POP_FRONT, MODE_POP_REAR: begin
               if (empty_ff) begin
                  status_in = ST_EMPTY;
               end else if (head_ff == tail_ff) begin
                  head_in = '0;
                  tail_in = '0;
                  empty_in = 1'b1;
               end else if (mode_ff == MODE_POP_FRONT) begin
                  head_in = head_inc;
               end else begin
                  tail_in = tail_dec;
               end
            end
            default: status_in = ST_DONE;
         endcase
      end
   end

   always_comb begin
      rsp_in.status = status_ff;
      rsp_in.front_value = empty_ff ? '0 : rd_head_ff;
      rsp_in.rear_value = empty_ff ? '0 : rd_tail_ff;
      rsp_in.is_empty = empty_ff;
      rsp_in.is_full = full_now;
   end

   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         empty_ff <= 1'b1;
         cap_ff <= CAP_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         empty_ff <= empty_in;
         cap_ff <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_data.mode;
         value_ff <= req_data.value;
      end
      status_ff <= status_in;
      if (cmd.load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_addr] <= value_ff;
      end
      if (cmd.read) begin
         rd_head_ff <= store[head_ff];
         rd_tail_ff <= store[tail_ff];
      end
   end

   assign rsp_data = rsp_ff;
   assign stat.rsp_full = rsp_valid_ff;

endmodule

// ===== rtl/circular_deque_top.sv =====
// Top level of the circular deque: controller and datapath.
//
// A double-ended queue of signed 32-bit words in a circular store of DEPTH
// entries, of which the capacity register sets how many are used.
// Request channel (req_valid/req_ready/req_data): one word asks to push at
// the front or rear, or to pop from the front or rear.
// Response channel (rsp_valid/rsp_ready/rsp_data): one word per request with
// the status, the front and rear words and the empty and full flags after
// the operation. A push to a full queue or a pop from an empty one is
// reported and leaves the queue unchanged.
// Each request goes through the update, the registered two-port read of the
// store and the load into the output register; a new request is accepted
// only once the previous one has been loaded and the sequencer is idle.
// The output register lets the next request enter while a response waits;
// when the receiver stalls, the following response holds in the load step.
// Reset (synchronous, active high) empties the queue and sets the capacity
// to 16 (or DEPTH if smaller). Write csr_wdata with csr_we only while idle;
// a write clamps the value to 1..DEPTH and empties the queue.
module circular_deque_top
   import cdq_pkg::*;
#(
   parameter int unsigned DEPTH = 16
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cdq_req_type      req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cdq_rsp_type      rsp_data,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata
);

   cdq_cmd_type  cmd;
   cdq_stat_type stat;

   // sequence each word through update, read and load
   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold the store, the indices and the response register
   cdq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

   assign rsp_valid = stat.rsp_full;

endmodule

// ===== verif/tb_circular_deque_top.sv =====
// Testbench for circular_deque_top: directed and random push/pop traffic checked by a scoreboard.
`timescale 1ns / 100ps

module tb_circular_deque_top;
   import cdq_pkg::*;

   localparam int unsigned DEPTH = 16;
   localparam int unsigned LATENCY = 4;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned PHASE_WORDS = 48;
   localparam int unsigned PRINT_CAP = 40;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   cdq_req_type      req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   cdq_rsp_type      rsp_data;
   logic             csr_we;
   logic [CAP_W-1:0] csr_wdata;

   // Mirror of the deque: its own store, indices and capacity register,
   // plus the list of responses still owed by the block.
   class deque_scoreboard;
      logic signed [VALUE_W-1:0] slots [DEPTH];
      int unsigned front_idx;
      int unsigned rear_idx;
      bit          vacant;
      logic [CAP_W-1:0] cap_reg;
      cdq_rsp_type owed_q[$];
      int unsigned mismatches;
      int unsigned words_in;
      int unsigned words_out;
      int unsigned status_tally [3];
      int unsigned full_tally;

      function new();
         cap_reg = CAP_W'(16);
         clear();
      endfunction

      function void clear();
         front_idx = 0;
         rear_idx = 0;
         vacant = 1'b1;
      endfunction

      // A write of the register also empties the queue.
      function void set_capacity(logic [CAP_W-1:0] v);
         cap_reg = v;
         clear();
      endfunction

      function int unsigned eff_cap();
         if (cap_reg == 0) return 1;
         if (cap_reg > DEPTH) return DEPTH;
         return cap_reg;
      endfunction

      function int unsigned step_up(int unsigned i, int unsigned c);
         return (i + 1 >= c) ? 0 : i + 1;
      endfunction

      function int unsigned step_down(int unsigned i, int unsigned c);
         return (i == 0) ? c - 1 : i - 1;
      endfunction

      function bit at_limit(int unsigned c);
         return !vacant && step_up(rear_idx, c) == front_idx;
      endfunction

      function int unsigned outstanding();
         return owed_q.size();
      endfunction

      // Advance the mirror by one accepted request word and queue the
      // response it must produce.
      function void note_request(cdq_req_type word);
         cdq_rsp_type want;
         int unsigned c;
         c = eff_cap();
         want.status = ST_DONE;
         case (word.mode)
            MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
               if (vacant) begin
                  front_idx = 0;
                  rear_idx = 0;
                  slots[0] = word.value;
                  vacant = 1'b0;
               end else if (at_limit(c)) begin
                  want.status = ST_FULL;
               end else if (word.mode == MODE_PUSH_FRONT) begin
                  front_idx = step_down(front_idx, c);
                  slots[front_idx] = word.value;
               end else begin
                  rear_idx = step_up(rear_idx, c);
                  slots[rear_idx] = word.value;
               end
            end
            default: begin
               if (vacant) begin
                  want.status = ST_EMPTY;
               end else if (front_idx == rear_idx) begin
                  clear();
               end else if (word.mode == MODE_POP_FRONT) begin
                  front_idx = step_up(front_idx, c);
               end else begin
                  rear_idx = step_down(rear_idx, c);
               end
            end
         endcase
         want.front_value = vacant ? '0 : slots[front_idx];
         want.rear_value = vacant ? '0 : slots[rear_idx];
         want.is_empty = vacant;
         want.is_full = at_limit(c);
         status_tally[want.status]++;
         if (want.is_full) full_tally++;
         words_in++;
         owed_q.push_back(want);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= PRINT_CAP)
            $display("%0t ns mismatch: %s", $time, what);
      endtask

      task check_response(cdq_rsp_type got);
         cdq_rsp_type want;
         words_out++;
         if (owed_q.size() == 0) begin
            report_mismatch($sformatf("response %0h with nothing outstanding", got));
            return;
         end
         want = owed_q.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
         if (got.front_value !== want.front_value)
            report_mismatch($sformatf("front got %0d want %0d",
                                      got.front_value, want.front_value));
         if (got.rear_value !== want.rear_value)
            report_mismatch($sformatf("rear got %0d want %0d",
                                      got.rear_value, want.rear_value));
         if (got.is_empty !== want.is_empty)
            report_mismatch($sformatf("empty flag got %b want %b",
                                      got.is_empty, want.is_empty));
         if (got.is_full !== want.is_full)
            report_mismatch($sformatf("full flag got %b want %b",
                                      got.is_full, want.is_full));
      endtask
   endclass

   deque_scoreboard sb;

   bit          sender_idles;
   bit          receiver_idles;
   int unsigned stall_left;
   int unsigned quiet_cycles;
   int unsigned cap_writes;

   circular_deque_top #(
      .DEPTH(DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Receiver: drop ready in random bursts of random length, changing at
   // the falling edge only.
   always @(negedge clock) begin
      if (stall_left == 0 && receiver_idles && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 10);
      if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // Sample the response channel at the rising edge and check each word.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         sb.check_response(rsp_data);
   end

   // Watchdog: count cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d cycles without a handshake", quiet_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic cdq_req_type make_req(logic [MODE_W-1:0] m,
                                             logic signed [VALUE_W-1:0] v);
      cdq_req_type word;
      word.mode = m;
      word.value = v;
      return word;
   endfunction

   // Favour the sign and range extremes now and then.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return '0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // Present one request word and hold it until accepted. Called at the
   // falling edge; returns at the falling edge after the handshake.
   task automatic send_word(cdq_req_type word);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = word;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(word);
      @(negedge clock);
   endtask

   // Drop valid, wait for every owed response, then allow the pipeline
   // latency to run out before anything else happens.
   task automatic settle();
      req_valid = 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] v);
      settle();
      csr_we = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      sb.set_capacity(v);
      cap_writes++;
   endtask

   // Random traffic: alternate fill and drain stretches so the queue swings
   // between empty and full, with a tenth of the words fully random.
   task automatic random_phase(int unsigned count);
      bit filling;
      int unsigned chunk_left;
      int unsigned roll;
      logic [MODE_W-1:0] m;
      filling = 1'b0;
      chunk_left = 0;
      for (int unsigned i = 0; i < count; i++) begin
         if (chunk_left == 0) begin
            filling = !filling;
            chunk_left = $urandom_range(3, 2 * sb.eff_cap() + 6);
         end
         chunk_left--;
         roll = $urandom_range(0, 9);
         if (roll == 0)
            m = MODE_W'($urandom_range(0, 3));
         else if (filling == (roll <= 7))
            m = $urandom_range(0, 1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
         else
            m = $urandom_range(0, 1) ? MODE_POP_REAR : MODE_POP_FRONT;
         send_word(make_req(m, pick_value()));
      end
   endtask

   initial begin
      logic [CAP_W-1:0] caps [11];
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      stall_left = 0;
      quiet_cycles = 0;
      cap_writes = 0;
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed: reset capacity, pops on empty, extremes, last pop.
      send_word(make_req(MODE_POP_FRONT, 32'sd7));
      send_word(make_req(MODE_POP_REAR, -32'sd7));
      send_word(make_req(MODE_PUSH_FRONT, 32'sh8000_0000));
      send_word(make_req(MODE_PUSH_REAR, 32'sh7FFF_FFFF));
      send_word(make_req(MODE_PUSH_FRONT, -32'sd1));
      send_word(make_req(MODE_PUSH_REAR, '0));
      send_word(make_req(MODE_POP_FRONT, '0));
      send_word(make_req(MODE_POP_REAR, '0));
      send_word(make_req(MODE_POP_FRONT, '0));
      send_word(make_req(MODE_POP_REAR, '0));
      send_word(make_req(MODE_POP_REAR, '0));

      // Zero capacity behaves as one: while an item is held, a further push is rejected.
      write_capacity(CAP_W'(0));
      send_word(make_req(MODE_PUSH_REAR, 32'sh5A5A_5A5A));
      send_word(make_req(MODE_PUSH_FRONT, 32'sh1234_5678));
      send_word(make_req(MODE_PUSH_REAR, 32'sh1234_5678));
      send_word(make_req(MODE_POP_FRONT, '0));
      send_word(make_req(MODE_PUSH_FRONT, 32'shA5A5_A5A5));
      send_word(make_req(MODE_POP_REAR, '0));
      send_word(make_req(MODE_PUSH_FRONT, 32'sh0F0F_0F0F));

      // Write while an item is held: the queue must come back empty.
      write_capacity(CAP_W'(2));
      send_word(make_req(MODE_POP_FRONT, '0));
      send_word(make_req(MODE_PUSH_FRONT, 32'sh3C3C_3C3C));
      send_word(make_req(MODE_PUSH_FRONT, -32'sd1000));
      send_word(make_req(MODE_PUSH_REAR, 32'sd99));
      send_word(make_req(MODE_POP_REAR, '0));
      send_word(make_req(MODE_POP_FRONT, '0));

      // Random phases over a spread of capacities, the clamped ones too.
      caps = '{CAP_W'(31), CAP_W'(3), CAP_W'(16), CAP_W'(1), CAP_W'(7), CAP_W'(17),
               CAP_W'(0), CAP_W'(2), CAP_W'($urandom_range(1, 16)), CAP_W'(16),
               CAP_W'(5)};
      foreach (caps[p]) begin
         write_capacity(caps[p]);
         // Give one middle phase and the closing phases a clean stretch.
         sender_idles = !(p == 3 || p >= 9);
         receiver_idles = !(p == 3 || p >= 9);
         random_phase(PHASE_WORDS);
      end

      settle();
      $display("ran %0d requests and checked %0d responses over %0d capacity writes",
               sb.words_in, sb.words_out, cap_writes);
      $display("statuses: %0d done, %0d rejected full, %0d rejected empty; %0d full flags",
               sb.status_tally[ST_DONE], sb.status_tally[ST_FULL],
               sb.status_tally[ST_EMPTY], sb.full_tally);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches, %0d responses missing", sb.mismatches, sb.outstanding());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
